### rtl/dat_pkg.sv
// Shared types and constants for the deferred action timer table.
`default_nettype none

package dat_pkg;

    localparam int COORD_W = 8;
    localparam int TIMER_W = 4;

    // Request codes carried by the req_type field.
    localparam logic REQ_SCHEDULE = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    localparam logic [TIMER_W-1:0] DELAY_RESET = 4'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIMER_W-1:0] timer;
        logic               flag;
    } entry_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               energizer;
        logic               last;
    } result_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

endpackage

`default_nettype wire

### rtl/dat_entry_unit.sv
// Shared compare and timer unit applied to the entry currently read from the table.
`default_nettype none

module dat_entry_unit (
    input  dat_pkg::entry_t                      cur,
    input  logic [dat_pkg::COORD_W-1:0]          req_x,
    input  logic [dat_pkg::COORD_W-1:0]          req_y,
    input  logic                                 req_flag,
    input  logic [dat_pkg::TIMER_W-1:0]          delay,
    output logic                                 match,
    output logic                                 expired,
    output dat_pkg::entry_t                      refreshed,
    output dat_pkg::entry_t                      decremented
);

    assign match   = (cur.x == req_x) && (cur.y == req_y);
    assign expired = (cur.timer == '0);

    always_comb begin
        refreshed       = cur;
        refreshed.timer = delay;
        refreshed.flag  = cur.flag | req_flag;
    end

    always_comb begin
        decremented       = cur;
        decremented.timer = cur.timer - dat_pkg::TIMER_W'(1);
    end

endmodule

`default_nettype wire

### rtl/dat_engine.sv
// Sequencer and entry memory that walk the table one entry per step.
`default_nettype none

module dat_engine #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [dat_pkg::COORD_W-1:0]    s_pos_x,
    input  logic [dat_pkg::COORD_W-1:0]    s_pos_y,
    input  logic                           s_energizer,
    input  logic [dat_pkg::TIMER_W-1:0]    delay,
    input  logic                           out_free,
    output dat_pkg::push_t                 push
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TICK_CHK,
        ST_TICK_LAST,
        ST_FLUSH
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [dat_pkg::COORD_W-1:0]  req_x_reg, req_x_next;
    logic [dat_pkg::COORD_W-1:0]  req_y_reg, req_y_next;
    logic                         req_flag_reg, req_flag_next;
    logic                         pend_valid_reg, pend_valid_next;
    dat_pkg::entry_t              pend_reg, pend_next;

    dat_pkg::entry_t              mem [TABLE_DEPTH];
    dat_pkg::entry_t              rd_data_reg;
    logic                         we;
    logic [IDX_W-1:0]             waddr;
    dat_pkg::entry_t              wdata;
    logic                         rd_en;
    logic [IDX_W-1:0]             raddr;

    logic                         match;
    logic                         expired;
    dat_pkg::entry_t              refreshed;
    dat_pkg::entry_t              decremented;
    logic [CNT_W-1:0]             idx_inc;
    logic [CNT_W-1:0]             cnt_dec;
    logic                         is_tail;

    dat_entry_unit u_unit (
        .cur         (rd_data_reg),
        .req_x       (req_x_reg),
        .req_y       (req_y_reg),
        .req_flag    (req_flag_reg),
        .delay       (delay),
        .match       (match),
        .expired     (expired),
        .refreshed   (refreshed),
        .decremented (decremented)
    );

    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign is_tail = (idx_inc == count_reg);
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        req_x_next      = req_x_reg;
        req_y_next      = req_y_reg;
        req_flag_next   = req_flag_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = refreshed;
        rd_en           = 1'b0;
        raddr           = idx_reg;
        push            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == dat_pkg::REQ_TICK) begin
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            raddr      = '0;
                            idx_next   = '0;
                            state_next = ST_TICK_CHK;
                        end
                    end else begin
                        req_x_next    = s_pos_x;
                        req_y_next    = s_pos_y;
                        req_flag_next = s_energizer;
                        if (count_reg == '0) begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = '{x: s_pos_x, y: s_pos_y, timer: delay,
                                           flag: s_energizer};
                            count_next = CNT_W'(1);
                        end else begin
                            rd_en      = 1'b1;
                            raddr      = '0;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    we         = 1'b1;
                    waddr      = idx_reg;
                    wdata      = refreshed;
                    state_next = ST_IDLE;
                end else if (is_tail) begin
                    // No entry holds this coordinate: append when there is room.
                    if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                        we         = 1'b1;
                        waddr      = count_reg[IDX_W-1:0];
                        wdata      = '{x: req_x_reg, y: req_y_reg, timer: delay,
                                       flag: req_flag_reg};
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end else begin
                    rd_en    = 1'b1;
                    raddr    = idx_inc[IDX_W-1:0];
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            ST_TICK_CHK: begin
                if (!expired) begin
                    we    = 1'b1;
                    waddr = idx_reg;
                    wdata = decremented;
                    if (is_tail) begin
                        state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        raddr    = idx_inc[IDX_W-1:0];
                        idx_next = idx_inc[IDX_W-1:0];
                    end
                end else if (!pend_valid_reg || out_free) begin
                    // The held result is not the last of this tick, since another
                    // entry has expired after it.
                    if (pend_valid_reg) begin
                        push.valid          = 1'b1;
                        push.data.x         = pend_reg.x;
                        push.data.y         = pend_reg.y;
                        push.data.energizer = pend_reg.flag;
                        push.data.last      = 1'b0;
                    end
                    pend_next       = rd_data_reg;
                    pend_valid_next = 1'b1;
                    if (is_tail) begin
                        count_next = cnt_dec;
                        state_next = ST_FLUSH;
                    end else begin
                        rd_en      = 1'b1;
                        raddr      = cnt_dec[IDX_W-1:0];
                        state_next = ST_TICK_LAST;
                    end
                end
            end
            ST_TICK_LAST: begin
                // The last entry moves into the freed slot and is examined there
                // straight from the read register.
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = rd_data_reg;
                count_next = cnt_dec;
                state_next = ST_TICK_CHK;
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push.valid          = 1'b1;
                    push.data.x         = pend_reg.x;
                    push.data.y         = pend_reg.y;
                    push.data.energizer = pend_reg.flag;
                    push.data.last      = 1'b1;
                    pend_valid_next     = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_x_reg    <= req_x_next;
        req_y_reg    <= req_y_next;
        req_flag_reg <= req_flag_next;
        pend_reg     <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    a_count_bounded : assert property (
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_idle_no_pending : assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("held result left over when accepting a new item");

    a_no_rw_collision : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (we && rd_en) |-> (waddr != raddr))
        else $error("read and write hit the same entry in one cycle");

    a_last_ends_tick : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (push.valid && push.data.last) |=> (state_reg == ST_IDLE))
        else $error("tick continued after its final result");

    a_push_has_room : assert property (
        @(posedge aclk) disable iff (!aresetn)
        push.valid |-> out_free)
        else $error("result pushed while the output register is full");

endmodule

`default_nettype wire

### rtl/deferred_action_timer_table.sv
// Top level of the deferred action timer table: configuration and output registers.
//
// Input channel (s_*): one item is either a schedule request (s_req_type 0) that
// refreshes the entry with the same coordinate or appends one while not full, or a frame
// tick (s_req_type 1) that counts every entry down and emits each expired one.
// Result channel (m_*): one item per expired entry, in expiry order; m_last marks
// the final one of a tick. A tick with nothing expired and every schedule request
// give no result.
// Operation: the table is one memory walked one entry per cycle through a single
// read port, but for the refill steps and while a result waits for room. A schedule
// request is accepted, then compared against one entry after another until a match
// or the tail. A tick is accepted, then examines each entry; an expired entry not at
// the tail is refilled from the tail, and the final result is handed over last.
// s_ready is high only while no item is in work. cfg_wr_en / cfg_wr_data write the
// delay register. Reset empties the table and loads a delay of 3 frames; no clearing
// pass is run. When the receiver stalls, one result waits in the output register and
// one more is held in the engine; the walk halts at the next expired entry, and the
// final result of a tick keeps s_ready low until the output register has room.
`default_nettype none

module deferred_action_timer_table #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dat_pkg::TIMER_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [dat_pkg::COORD_W-1:0]   s_pos_x,
    input  logic [dat_pkg::COORD_W-1:0]   s_pos_y,
    input  logic                          s_energizer,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dat_pkg::COORD_W-1:0]   m_out_x,
    output logic [dat_pkg::COORD_W-1:0]   m_out_y,
    output logic                          m_out_energizer,
    output logic                          m_last
);

    logic [dat_pkg::TIMER_W-1:0] delay_reg;
    logic                        m_valid_reg;
    dat_pkg::result_t            result_reg;
    logic                        out_free;
    dat_pkg::push_t              push;

    assign out_free = !m_valid_reg || m_ready;

    dat_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_energizer (s_energizer),
        .delay       (delay_reg),
        .out_free    (out_free),
        .push        (push)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= dat_pkg::DELAY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
            if (push.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            result_reg <= push.data;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = result_reg.x;
    assign m_out_y         = result_reg.y;
    assign m_out_energizer = result_reg.energizer;
    assign m_last          = result_reg.last;

endmodule

`default_nettype wire
